// File: design/sal_pkg.sv
`default_nettype none
package sal_pkg;

  localparam int NumPages        = 64;
  localparam int PageBytes       = 4096;
  localparam int MaxSlots        = 128;
  localparam int GuardBytes      = 16;
  localparam int PageHeaderBytes = 24;
  localparam int SlotHeaderBytes = 4;
  localparam int SlotHeaderAlign = 2;

  localparam int PageW   = $clog2(NumPages);
  localparam int PtrW    = PageW + 1;
  localparam int SlotW   = $clog2(MaxSlots);
  localparam int LinkW   = SlotW + 1;
  localparam int OffW    = $clog2(PageBytes);
  localparam int AddrW   = 18;
  localparam int LayW    = 14;
  localparam int DivW    = OffW + 1;
  localparam int SizeW   = 12;
  localparam int AlignW  = 11;
  localparam int CntW    = 8;
  localparam int StatusW = 3;

  localparam logic [PtrW-1:0] NoPage = PtrW'(NumPages);

  localparam logic CFG_PAYLOAD_BYTES = 1'b0;
  localparam logic CFG_PAYLOAD_ALIGN = 1'b1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_PAGE   = 3'd1,
    ST_NOT_ALLOC = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_BAD_CFG   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LAYOUT,
    S_DIV,
    S_DISPATCH,
    S_THREAD,
    S_PG_RD,
    S_PG_DATA,
    S_AL_SLOT,
    S_FR_RD,
    S_FR_DATA,
    S_RM,
    S_RM_B_WR,
    S_RM_F,
    S_RM_F_WR,
    S_PB_RD,
    S_PB_WR,
    S_DONE
  } fsm_state_e;

  typedef struct packed {
    logic [LinkW-1:0] head;
    logic [CntW-1:0]  cnt;
    logic [PtrW-1:0]  fwd;
    logic [PtrW-1:0]  bwd;
  } page_ent_t;

  typedef struct packed {
    logic             in_use;
    logic [LinkW-1:0] link;
  } slot_ent_t;

endpackage
`default_nettype wire

// File: design/slab_object_allocator_top.sv
`default_nettype none
// Slab object allocator for a pool of 64 pages of 4096 bytes.
// Input stream: tuser[0] selects allocate (0) or free (1); tdata[17:0] is the
// payload address to free. Each transaction returns exactly one result on the
// output stream: address, status, page-taken and page-returned flags, page.
// The config port writes the payload size (index 0) and the payload alignment
// (index 1); write it only while no transaction is in flight.
// One transaction is processed at a time; the input is ready only when idle.
// A transaction goes straight to its result when the configuration is bad or,
// for a free, the offset lies ahead of the first payload. Otherwise it runs
// a 13-step restoring divider for the slot layout, then read-modify-write
// passes over the page memory for the slot lists and the partial-page list.
// An allocation that takes a fresh page first threads its slots, up to 128.
// Reset empties the partial list, marks every page free and restores a 64-byte
// payload with 8-byte alignment; no clearing pass is needed.
// A finished result sits in an output register; the next input is accepted
// while it waits, and the block holds the following result until the
// receiver takes the previous one.
module slab_object_allocator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // object_address[17:0]
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_address[17:0], status[20:18], page_taken[21], page_returned[22],
  // page_number[28:23]
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [11:0] cfg_wdata_i
);
  import sal_pkg::*;

  fsm_state_e state_q, state_d;

  logic [SizeW-1:0]  size_q;
  logic [AlignW-1:0] align_q;

  logic              func_q, func_d;
  logic [AddrW-1:0]  oaddr_q, oaddr_d;
  logic [LayW-1:0]   page_off_q, page_off_d, pay_off_q, pay_off_d, slot_sz_q, slot_sz_d;
  logic [LayW-1:0]   div_rem_q, div_rem_d;
  logic [DivW-1:0]   div_quo_q, div_quo_d;
  logic [3:0]        div_cnt_q, div_cnt_d;
  logic [LinkW-1:0]  slots_q, slots_d, thr_q, thr_d;
  logic [PageW-1:0]  pg_q, pg_d;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PtrW-1:0]   rm_f_q, rm_f_d, rm_b_q, rm_b_d;
  logic [PtrW-1:0]   first_q, first_d, last_q, last_d;
  logic [NumPages-1:0] pool_q, pool_d, page_vld_q;
  logic              pg_rd_vld_q;

  logic [AddrW-1:0]  r_addr_q, r_addr_d;
  status_e           r_status_q, r_status_d;
  logic              r_taken_q, r_taken_d, r_ret_q, r_ret_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_data_q, out_data_d;

  // memories
  slot_ent_t slot_mem [NumPages*MaxSlots];
  page_ent_t page_mem [NumPages];
  slot_ent_t slot_rd_q, slot_wdata;
  page_ent_t page_rd_q, page_wdata, pg_ent;
  logic      slot_we, page_we;
  logic [PageW+SlotW-1:0] slot_waddr, slot_raddr;
  logic [PageW-1:0]       page_waddr, page_raddr;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
    if (page_we) begin
      page_mem[page_waddr] <= page_wdata;
    end
    page_rd_q <= page_mem[page_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_vld_q  <= '0;
      pg_rd_vld_q <= 1'b0;
    end else begin
      pg_rd_vld_q <= page_vld_q[page_raddr];
      if (page_we) begin
        page_vld_q[page_waddr] <= 1'b1;
      end
    end
  end

  // never-written page entries read as empty
  assign pg_ent = pg_rd_vld_q ? page_rd_q : page_ent_t'('0);

  // slot layout from the configuration
  logic [LayW-1:0] a14, amax, lay_page_off, lay_pay_off, lay_raw, lay_slot_sz;
  logic            lay_bad;
  always_comb begin
    a14          = LayW'(align_q);
    amax         = (a14 > LayW'(SlotHeaderAlign)) ? a14 : LayW'(SlotHeaderAlign);
    lay_page_off = (LayW'(PageHeaderBytes) + amax - 1'b1) & ~(amax - 1'b1);
    lay_pay_off  = (LayW'(SlotHeaderBytes + GuardBytes) + a14 - 1'b1) & ~(a14 - 1'b1);
    lay_raw      = lay_pay_off + LayW'(size_q) + LayW'(GuardBytes);
    lay_slot_sz  = (lay_raw + a14 - 1'b1) & ~(a14 - 1'b1);
    lay_bad      = (size_q == '0) || (align_q == '0) || ((align_q & (align_q - 1'b1)) != '0)
                   || ({1'b0, lay_page_off} + {1'b0, lay_slot_sz} > (LayW+1)'(PageBytes));
  end

  logic [PageW-1:0] low_free;
  always_comb begin
    low_free = '0;
    for (int i = NumPages - 1; i >= 0; i--) begin
      if (pool_q[i]) begin
        low_free = PageW'(i);
      end
    end
  end

  logic [OffW-1:0]  off;
  logic [LayW-1:0]  fr_base;
  logic [DivW:0]    div_t;
  logic [LayW+SlotW-1:0] prod;
  logic [AddrW+2:0] addr_sum;
  logic             fr_ok;
  always_comb begin
    off      = oaddr_q[OffW-1:0];
    fr_base  = lay_page_off + lay_pay_off;
    div_t    = {div_rem_q[DivW-1:0], div_quo_q[DivW-1]};
    prod     = idx_q * slot_sz_q;
    addr_sum = (AddrW+3)'({pg_q, {OffW{1'b0}}}) + (AddrW+3)'(page_off_q)
               + (AddrW+3)'(prod) + (AddrW+3)'(pay_off_q);
    fr_ok    = (div_rem_q == '0) && (div_quo_q < DivW'(MaxSlots))
               && ((LayW+1)'(off) - (LayW+1)'(pay_off_q) + (LayW+1)'(slot_sz_q)
                   <= (LayW+1)'(PageBytes));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (s_axis_tvalid) state_d = S_LAYOUT;
      S_LAYOUT: begin
        if (lay_bad) state_d = S_DONE;
        else if (func_q != FUNC_ALLOC && LayW'(off) < fr_base) state_d = S_DONE;
        else state_d = S_DIV;
      end
      S_DIV:      if (div_cnt_q == 4'd1) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (func_q == FUNC_ALLOC) begin
          if (first_q != NoPage) state_d = S_PG_RD;
          else if (pool_q == '0) state_d = S_DONE;
          else state_d = S_THREAD;
        end else if (!fr_ok || pool_q[oaddr_q[AddrW-1:OffW]]) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FR_RD;
        end
      end
      S_THREAD:   if (thr_q == slots_q - 1'b1) state_d = S_PG_RD;
      S_PG_RD:    state_d = S_PG_DATA;
      S_PG_DATA:  state_d = (pg_ent.head == '0) ? S_RM : S_AL_SLOT;
      S_AL_SLOT:  state_d = (slot_rd_q.link == '0) ? S_RM : S_DONE;
      S_FR_RD:    state_d = S_FR_DATA;
      S_FR_DATA: begin
        if (!slot_rd_q.in_use) state_d = S_DONE;
        else if (pg_ent.cnt == CntW'(1)) state_d = (pg_ent.head == '0) ? S_DONE : S_RM;
        else if (pg_ent.head == '0) state_d = (last_q != NoPage) ? S_PB_RD : S_DONE;
        else state_d = S_DONE;
      end
      S_RM:       state_d = (rm_b_q != NoPage) ? S_RM_B_WR : S_RM_F;
      S_RM_B_WR:  state_d = S_RM_F;
      S_RM_F:     state_d = (rm_f_q != NoPage) ? S_RM_F_WR : S_DONE;
      S_RM_F_WR:  state_d = S_DONE;
      S_PB_RD:    state_d = S_PB_WR;
      S_PB_WR:    state_d = S_DONE;
      S_DONE:     if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    func_d = func_q;  oaddr_d = oaddr_q;
    page_off_d = page_off_q;  pay_off_d = pay_off_q;  slot_sz_d = slot_sz_q;
    div_rem_d = div_rem_q;  div_quo_d = div_quo_q;  div_cnt_d = div_cnt_q;
    slots_d = slots_q;  thr_d = thr_q;  pg_d = pg_q;  idx_d = idx_q;
    cnt_d = cnt_q;  rm_f_d = rm_f_q;  rm_b_d = rm_b_q;
    first_d = first_q;  last_d = last_q;  pool_d = pool_q;
    r_addr_d = r_addr_q;  r_status_d = r_status_q;
    r_taken_d = r_taken_q;  r_ret_d = r_ret_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    slot_we = 1'b0;  slot_waddr = {pg_q, idx_q};  slot_raddr = {pg_q, idx_q};
    slot_wdata = slot_ent_t'('0);
    page_we = 1'b0;  page_waddr = pg_q;  page_raddr = pg_q;
    page_wdata = page_ent_t'('0);

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        func_d     = s_axis_tuser[0];
        oaddr_d    = s_axis_tdata[AddrW-1:0];
        r_addr_d   = '0;
        r_status_d = ST_OK;
        r_taken_d  = 1'b0;
        r_ret_d    = 1'b0;
        pg_d       = '0;
      end
      S_LAYOUT: begin
        page_off_d = lay_page_off;
        pay_off_d  = lay_pay_off;
        slot_sz_d  = lay_slot_sz;
        div_rem_d  = '0;
        div_cnt_d  = 4'(DivW);
        div_quo_d  = (func_q == FUNC_ALLOC) ? DivW'(PageBytes) - DivW'(lay_page_off)
                                            : DivW'(off) - DivW'(fr_base);
        if (func_q != FUNC_ALLOC) pg_d = oaddr_q[AddrW-1:OffW];
        if (lay_bad) begin
          r_status_d = ST_BAD_CFG;
          pg_d       = '0;
        end else if (func_q != FUNC_ALLOC && LayW'(off) < fr_base) begin
          r_status_d = ST_BAD_ADDR;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (div_t >= (DivW+1)'(slot_sz_q)) begin
          div_rem_d = LayW'(div_t - (DivW+1)'(slot_sz_q));
          div_quo_d = {div_quo_q[DivW-2:0], 1'b1};
        end else begin
          div_rem_d = LayW'(div_t);
          div_quo_d = {div_quo_q[DivW-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q - 1'b1;
      end
      S_DISPATCH: begin
        slots_d = (div_quo_q > DivW'(MaxSlots)) ? LinkW'(MaxSlots) : LinkW'(div_quo_q);
        idx_d   = SlotW'(div_quo_q);
        thr_d   = '0;
        if (func_q == FUNC_ALLOC) begin
          if (first_q != NoPage) begin
            pg_d = first_q[PageW-1:0];
          end else if (pool_q == '0) begin
            r_status_d = ST_NO_PAGE;
          end else begin
            pg_d = low_free;
            pool_d[low_free] = 1'b0;
          end
        end else if (!fr_ok) begin
          r_status_d = ST_BAD_ADDR;
        end else if (pool_q[pg_q]) begin
          r_status_d = ST_NOT_ALLOC;
        end
      end
      S_THREAD: begin
        // link each slot to the next, ascending
        slot_we    = 1'b1;
        slot_waddr = {pg_q, thr_q[SlotW-1:0]};
        slot_wdata.in_use = 1'b0;
        slot_wdata.link   = (thr_q + 1'b1 < slots_q) ? thr_q + LinkW'(2) : '0;
        thr_d = thr_q + 1'b1;
        if (thr_q == slots_q - 1'b1) begin
          page_we    = 1'b1;
          page_wdata = '{head: LinkW'(1), cnt: '0, fwd: NoPage, bwd: NoPage};
          first_d    = PtrW'(pg_q);
          last_d     = PtrW'(pg_q);
          r_taken_d  = 1'b1;
        end
      end
      S_PG_RD: ;
      S_PG_DATA: begin
        rm_f_d = pg_ent.fwd;
        rm_b_d = pg_ent.bwd;
        cnt_d  = pg_ent.cnt;
        idx_d  = SlotW'(pg_ent.head - 1'b1);
        slot_raddr = {pg_q, SlotW'(pg_ent.head - 1'b1)};
        if (pg_ent.head == '0) r_status_d = ST_NO_PAGE;
      end
      S_AL_SLOT: begin
        page_we    = 1'b1;
        page_wdata = '{head: slot_rd_q.link, cnt: cnt_q + 1'b1, fwd: rm_f_q, bwd: rm_b_q};
        slot_we    = 1'b1;
        slot_wdata = '{in_use: 1'b1, link: '0};
        r_addr_d   = addr_sum[AddrW-1:0];
      end
      S_FR_RD: ;
      S_FR_DATA: begin
        rm_f_d = pg_ent.fwd;
        rm_b_d = pg_ent.bwd;
        if (!slot_rd_q.in_use) begin
          r_status_d = ST_NOT_ALLOC;
        end else begin
          slot_we    = 1'b1;
          slot_wdata = '{in_use: 1'b0, link: pg_ent.head};
          page_we    = 1'b1;
          page_wdata = '{head: LinkW'(idx_q) + 1'b1, cnt: pg_ent.cnt - 1'b1,
                         fwd: pg_ent.fwd, bwd: pg_ent.bwd};
          if (pg_ent.cnt == CntW'(1)) begin
            pool_d[pg_q] = 1'b1;
            r_ret_d      = 1'b1;
          end else if (pg_ent.head == '0) begin
            // page was full: append it to the partial list
            page_wdata.fwd = NoPage;
            page_wdata.bwd = last_q;
            if (last_q == NoPage) begin
              first_d = PtrW'(pg_q);
              last_d  = PtrW'(pg_q);
            end
          end
        end
      end
      S_RM: begin
        page_raddr = rm_b_q[PageW-1:0];
        if (rm_b_q == NoPage) first_d = rm_f_q;
      end
      S_RM_B_WR: begin
        page_we    = 1'b1;
        page_waddr = rm_b_q[PageW-1:0];
        page_wdata = page_rd_q;
        page_wdata.fwd = rm_f_q;
      end
      S_RM_F: begin
        page_raddr = rm_f_q[PageW-1:0];
        if (rm_f_q == NoPage) last_d = rm_b_q;
      end
      S_RM_F_WR: begin
        page_we    = 1'b1;
        page_waddr = rm_f_q[PageW-1:0];
        page_wdata = page_rd_q;
        page_wdata.bwd = rm_b_q;
      end
      S_PB_RD: begin
        page_raddr = last_q[PageW-1:0];
      end
      S_PB_WR: begin
        page_we    = 1'b1;
        page_waddr = last_q[PageW-1:0];
        page_wdata = page_rd_q;
        page_wdata.fwd = PtrW'(pg_q);
        last_d     = PtrW'(pg_q);
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, pg_q, r_ret_q, r_taken_q, r_status_q, r_addr_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SizeW'(64);
      align_q     <= AlignW'(8);
      first_q     <= NoPage;
      last_q      <= NoPage;
      pool_q      <= '1;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      pool_q      <= pool_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
      if (cfg_we_i) begin
        if (cfg_index_i[0] == CFG_PAYLOAD_BYTES) size_q <= cfg_wdata_i[SizeW-1:0];
        if (cfg_index_i[0] == CFG_PAYLOAD_ALIGN) align_q <= cfg_wdata_i[AlignW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;  oaddr_q <= oaddr_d;
    page_off_q <= page_off_d;  pay_off_q <= pay_off_d;  slot_sz_q <= slot_sz_d;
    div_rem_q <= div_rem_d;  div_quo_q <= div_quo_d;
    slots_q <= slots_d;  thr_q <= thr_d;  pg_q <= pg_d;  idx_q <= idx_d;
    cnt_q <= cnt_d;  rm_f_q <= rm_f_d;  rm_b_q <= rm_b_d;
    r_addr_q <= r_addr_d;  r_status_q <= r_status_d;
    r_taken_q <= r_taken_d;  r_ret_q <= r_ret_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
